/* rtl/btws_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, command codes and divider status type for the block time
// window statistics block. No dependencies.
package btws_pkg;

   localparam int CMD_W      = 1;
   localparam int TIME_W     = 32;
   localparam int DIFF_W     = 7;
   localparam int AMOUNT_W   = 32;
   localparam int COUNT_W    = 32;
   localparam int AVG_W      = 32;
   localparam int TOTAL_W    = 48;
   localparam int FILL_OUT_W = 7;

   localparam int WINDOW_DEF = 100;

   localparam logic [CMD_W-1:0] CMD_RECORD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/btws_ifs.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready plus payload).
// Depends on btws_pkg.
interface btws_req_if import btws_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [TIME_W-1:0]   block_time;
   logic [DIFF_W-1:0]   difficulty;
   logic [AMOUNT_W-1:0] reward;
   logic [AMOUNT_W-1:0] fees;

   modport source (output valid, cmd, block_time, difficulty, reward, fees, input ready);
   modport sink (input valid, cmd, block_time, difficulty, reward, fees, output ready);
endinterface

interface btws_rsp_if import btws_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_W-1:0]    blocks_mined;
   logic [AVG_W-1:0]      average_time;
   logic [TIME_W-1:0]     fastest_time;
   logic [TIME_W-1:0]     slowest_time;
   logic [DIFF_W-1:0]     last_difficulty;
   logic [TOTAL_W-1:0]    total_reward;
   logic [TOTAL_W-1:0]    total_fees;
   logic [FILL_OUT_W-1:0] window_fill;

   modport source (output valid, blocks_mined, average_time, fastest_time, slowest_time,
                   last_difficulty, total_reward, total_fees, window_fill, input ready);
   modport sink (input valid, blocks_mined, average_time, fastest_time, slowest_time,
                 last_difficulty, total_reward, total_fees, window_fill, output ready);
endinterface

/* rtl/btws_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/btws_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider: window sum / fill count, one quotient bit
// per cycle. Depends on btws_pkg.
module btws_div import btws_pkg::*; #(
   parameter int SUM_W  = 39,
   parameter int FILL_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [FILL_W-1:0]  divisor,
   output logic [AVG_W-1:0]   quotient,
   output div_stat_type       stat
);

   localparam int CNT_W = $clog2(AVG_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(AVG_W - 1);

   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [AVG_W-1:0]  quo_ff, quo_in;
   logic [FILL_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [FILL_W:0]   trial;
   logic [FILL_W:0]   diff;
   logic              fits;

   // Quotient shares the shift register with the low dividend bits; the
   // high dividend bits start as remainder since the quotient fits AVG_W bits.
   always_comb begin
      trial   = {rem_ff, quo_ff[AVG_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = FILL_W'(dividend[SUM_W-1:AVG_W]);
         quo_in  = dividend[AVG_W-1:0];
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
         quo_in = {quo_ff[AVG_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/block_time_window_stats.sv */
`timescale 1ns / 1ps
// Top level of the block time window statistics block.
// Depends on btws_pkg, btws_ifs, btws_ram and btws_div.
//
//   channel  | dir | handshake     | carries
//   ---------+-----+---------------+---------------------------------------------
//   req_ch   | in  | valid / ready | cmd, block_time, difficulty, reward, fees
//   rsp_ch   | out | valid / ready | snapshot of all statistics after the item
//
// A record item passes through update (ring read data arrives with the accept),
// divider load, the bit-serial divider, quotient capture and output load before
// it reaches the output register; a clear item goes from accept straight to the
// output load step. One item is in work at a time; the next is taken once the
// previous result sits in the output register, even if unread, so no new item
// is accepted before the last one is through.
// A stalled output only holds the final load step. Synchronous reset
// zeroes all statistics; ring contents are never used before written.
module block_time_window_stats import btws_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input logic        clock,
   input logic        reset,
   btws_req_if.sink   req_ch,
   btws_rsp_if.source rsp_ch
);

   localparam int PTR_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = TIME_W + PTR_W;

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_UPD   = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]          state_ff, state_in;
   // latched item
   logic [TIME_W-1:0]   bt_ff, bt_in;
   logic [DIFF_W-1:0]   diff_ff, diff_in;
   logic [AMOUNT_W-1:0] rew_ff, rew_in;
   logic [AMOUNT_W-1:0] fee_ff, fee_in;
   // statistics
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]    wsum_ff, wsum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0]   min_ff, min_in;
   logic [TIME_W-1:0]   max_ff, max_in;
   logic [TOTAL_W-1:0]  rsum_ff, rsum_in;
   logic [TOTAL_W-1:0]  fsum_ff, fsum_in;
   logic [DIFF_W-1:0]   hdiff_ff, hdiff_in;
   logic [AVG_W-1:0]    avg_ff, avg_in;
   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  o_count_ff, o_count_in;
   logic [AVG_W-1:0]    o_avg_ff, o_avg_in;
   logic [TIME_W-1:0]   o_min_ff, o_min_in;
   logic [TIME_W-1:0]   o_max_ff, o_max_in;
   logic [DIFF_W-1:0]   o_diff_ff, o_diff_in;
   logic [TOTAL_W-1:0]  o_rsum_ff, o_rsum_in;
   logic [TOTAL_W-1:0]  o_fsum_ff, o_fsum_in;
   logic [FILL_OUT_W-1:0] o_fill_ff, o_fill_in;

   logic                req_acc;
   logic                out_free;
   logic                full;
   logic                ram_we;
   logic [TIME_W-1:0]   ram_rdata;
   logic [SUM_W-1:0]    wsum_less;
   logic [TOTAL_W:0]    rsum_wide;
   logic [TOTAL_W:0]    fsum_wide;
   logic                div_start;
   logic [AVG_W-1:0]    div_quo;
   div_stat_type        div_stat;

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign full     = fill_ff == FILL_FULL;

   btws_ram #(
      .WIDTH (TIME_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ptr_ff),
      .wr_data (bt_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   btws_div #(
      .SUM_W  (SUM_W),
      .FILL_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wsum_ff),
      .divisor  (fill_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   always_comb begin
      wsum_less = full ? (wsum_ff - SUM_W'(ram_rdata)) : wsum_ff;
      rsum_wide = {1'b0, rsum_ff} + (TOTAL_W + 1)'(rew_ff);
      fsum_wide = {1'b0, fsum_ff} + (TOTAL_W + 1)'(fee_ff);

      state_in     = state_ff;
      bt_in        = bt_ff;
      diff_in      = diff_ff;
      rew_in       = rew_ff;
      fee_in       = fee_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      wsum_in      = wsum_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsum_in      = rsum_ff;
      fsum_in      = fsum_ff;
      hdiff_in     = hdiff_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_count_in   = o_count_ff;
      o_avg_in     = o_avg_ff;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      o_diff_in    = o_diff_ff;
      o_rsum_in    = o_rsum_ff;
      o_fsum_in    = o_fsum_ff;
      o_fill_in    = o_fill_ff;
      ram_we       = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               bt_in   = req_ch.block_time;
               diff_in = req_ch.difficulty;
               rew_in  = req_ch.reward;
               fee_in  = req_ch.fees;
               if (req_ch.cmd == CMD_CLEAR) begin
                  ptr_in   = '0;
                  fill_in  = '0;
                  wsum_in  = '0;
                  count_in = '0;
                  min_in   = '0;
                  max_in   = '0;
                  rsum_in  = '0;
                  fsum_in  = '0;
                  hdiff_in = '0;
                  avg_in   = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_UPD;
               end
            end
         end
         S_UPD: begin
            // ring read data for ptr_ff is valid here
            ram_we = 1'b1;
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            rsum_in  = rsum_wide[TOTAL_W] ? '1 : rsum_wide[TOTAL_W-1:0];
            fsum_in  = fsum_wide[TOTAL_W] ? '1 : fsum_wide[TOTAL_W-1:0];
            hdiff_in = diff_ff;
            // zero means fastest not yet set
            if (min_ff == '0 || bt_ff < min_ff) begin
               min_in = bt_ff;
            end
            if (bt_ff > max_ff) begin
               max_in = bt_ff;
            end
            if (!full) begin
               fill_in = fill_ff + 1'b1;
            end
            wsum_in  = wsum_less + SUM_W'(bt_ff);
            ptr_in   = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               avg_in   = div_quo;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_count_in   = count_ff;
               o_avg_in     = avg_ff;
               o_min_in     = min_ff;
               o_max_in     = max_ff;
               o_diff_in    = hdiff_ff;
               o_rsum_in    = rsum_ff;
               o_fsum_in    = fsum_ff;
               o_fill_in    = FILL_OUT_W'(fill_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         wsum_ff      <= '0;
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsum_ff      <= '0;
         fsum_ff      <= '0;
         hdiff_ff     <= '0;
         avg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         wsum_ff      <= wsum_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsum_ff      <= rsum_in;
         fsum_ff      <= fsum_in;
         hdiff_ff     <= hdiff_in;
         avg_ff       <= avg_in;
      end
      bt_ff     <= bt_in;
      diff_ff   <= diff_in;
      rew_ff    <= rew_in;
      fee_ff    <= fee_in;
      o_count_ff <= o_count_in;
      o_avg_ff   <= o_avg_in;
      o_min_ff   <= o_min_in;
      o_max_ff   <= o_max_in;
      o_diff_ff  <= o_diff_in;
      o_rsum_ff  <= o_rsum_in;
      o_fsum_ff  <= o_fsum_in;
      o_fill_ff  <= o_fill_in;
   end

   assign req_ch.ready           = state_ff == S_IDLE;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.blocks_mined    = o_count_ff;
   assign rsp_ch.average_time    = o_avg_ff;
   assign rsp_ch.fastest_time    = o_min_ff;
   assign rsp_ch.slowest_time    = o_max_ff;
   assign rsp_ch.last_difficulty = o_diff_ff;
   assign rsp_ch.total_reward    = o_rsum_ff;
   assign rsp_ch.total_fees      = o_fsum_ff;
   assign rsp_ch.window_fill     = o_fill_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside output load");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL && ptr_ff <= PTR_LAST)
      else $error("window fill or ring pointer out of range");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> fill_ff != '0)
      else $error("divider started with empty window");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == S_DIV)
      else $error("divider busy outside divide state");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_ch.cmd == CMD_CLEAR |=> fill_ff == '0 && wsum_ff == '0 && count_ff == '0)
      else $error("clear item left statistics set");

endmodule

/* sim/btws_stats_checker.sv */
`timescale 1ns / 1ps
// Watches the request and response channels of block_time_window_stats,
// predicts each statistics snapshot and compares it. Depends on btws_pkg, btws_ifs.
module btws_stats_checker import btws_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic clock,
   input  logic reset,
   btws_req_if  req_ch,
   btws_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending,
   output int   checked
);

   localparam int SUM_W = TIME_W + 11;

   typedef struct packed {
      logic [COUNT_W-1:0]    blocks;
      logic [AVG_W-1:0]      avg;
      logic [TIME_W-1:0]     fastest;
      logic [TIME_W-1:0]     slowest;
      logic [DIFF_W-1:0]     diff;
      logic [TOTAL_W-1:0]    reward;
      logic [TOTAL_W-1:0]    fees;
      logic [FILL_OUT_W-1:0] fill;
   } stats_snap_type;

   stats_snap_type snap_q[$];

   // predicted statistics
   logic [TIME_W-1:0]   recent_times [WINDOW];
   int                  slot;
   int                  held;
   logic [SUM_W-1:0]    time_total;
   logic [COUNT_W-1:0]  block_tally;
   logic [TIME_W-1:0]   fastest;
   logic [TIME_W-1:0]   slowest;
   logic [TOTAL_W-1:0]  reward_total;
   logic [TOTAL_W-1:0]  fee_total;
   logic [DIFF_W-1:0]   diff_held;
   logic [AVG_W-1:0]    avg_held;

   function automatic logic [TOTAL_W-1:0] sat_total(logic [TOTAL_W-1:0] acc,
                                                    logic [AMOUNT_W-1:0] add);
      logic [TOTAL_W:0] s;
      s = {1'b0, acc} + (TOTAL_W+1)'(add);
      return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
   endfunction

   task automatic wipe_stats();
      slot         = 0;
      held         = 0;
      time_total   = '0;
      block_tally  = '0;
      fastest      = '0;
      slowest      = '0;
      reward_total = '0;
      fee_total    = '0;
      diff_held    = '0;
      avg_held     = '0;
   endtask

   task automatic record_block(logic [TIME_W-1:0] bt, logic [DIFF_W-1:0] d,
                               logic [AMOUNT_W-1:0] r, logic [AMOUNT_W-1:0] f);
      if (block_tally != '1) block_tally++;
      reward_total = sat_total(reward_total, r);
      fee_total    = sat_total(fee_total, f);
      diff_held    = d;
      // zero fastest means unset, so any time replaces it
      if (fastest == '0 || bt < fastest) fastest = bt;
      if (bt > slowest) slowest = bt;
      if (held >= WINDOW) time_total -= SUM_W'(recent_times[slot]);
      else held++;
      recent_times[slot] = bt;
      time_total += SUM_W'(bt);
      slot = (slot + 1) % WINDOW;
      avg_held = AVG_W'(time_total / SUM_W'(held));
   endtask

   task automatic compare_field(string name, logic [TOTAL_W-1:0] got,
                                logic [TOTAL_W-1:0] want);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch result %0d %s: expected %0h got %0h", checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      stats_snap_type want;
      stats_snap_type fresh;
      if (reset) begin
         wipe_stats();
         snap_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (snap_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result with nothing outstanding (result %0d)", checked);
            end else begin
               want = snap_q.pop_front();
               compare_field("blocks_mined", rsp_ch.blocks_mined, want.blocks);
               compare_field("average_time", rsp_ch.average_time, want.avg);
               compare_field("fastest_time", rsp_ch.fastest_time, want.fastest);
               compare_field("slowest_time", rsp_ch.slowest_time, want.slowest);
               compare_field("last_difficulty", rsp_ch.last_difficulty, want.diff);
               compare_field("total_reward", rsp_ch.total_reward, want.reward);
               compare_field("total_fees", rsp_ch.total_fees, want.fees);
               compare_field("window_fill", rsp_ch.window_fill, want.fill);
            end
            checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.cmd == CMD_CLEAR) wipe_stats();
            else record_block(req_ch.block_time, req_ch.difficulty, req_ch.reward, req_ch.fees);
            fresh.blocks  = block_tally;
            fresh.avg     = avg_held;
            fresh.fastest = fastest;
            fresh.slowest = slowest;
            fresh.diff    = diff_held;
            fresh.reward  = reward_total;
            fresh.fees    = fee_total;
            fresh.fill    = FILL_OUT_W'(held);
            snap_q = {snap_q, fresh};
         end
      end
      pending <= snap_q.size();
   end

endmodule

/* sim/block_time_window_stats_tb.sv */
`timescale 1ns / 1ps
// Testbench top for block_time_window_stats: clock, reset, stimulus and verdict.
// Depends on btws_pkg, btws_ifs, the block and btws_stats_checker.
module block_time_window_stats_tb import btws_pkg::*; ();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 700;
   localparam int CALM_ITEMS   = 120;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   btws_req_if req_ch ();
   btws_rsp_if rsp_ch ();

   block_time_window_stats DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   int fail_count;
   int pending;
   int checked;

   btws_stats_checker stats_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   bit calm;            // no idling on either side
   bit hold_off_req;    // ask the receiver for one long stall
   int back_to_back;    // items to send without gaps
   int records_sent;
   int clears_sent;
   int run_now;
   int run_max;
   int random_sent;
   int pressure_at;
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off, none when calm
   initial begin
      int stall_left;
      int run_left;
      int hold_left;
      bit hold_done;
      stall_left = 0;
      run_left   = 0;
      hold_left  = 0;
      hold_done  = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_off_req && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1;
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else if (run_left > 0) begin
            rsp_ch.ready <= 1'b1;
            run_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 10);
            stall_left = $urandom_range(0, 1) ? $urandom_range(1, 13) : 0;
         end
      end
   end

   task automatic sender_gap(int n);
      @(negedge clock);
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= CMD_W'($urandom_range(0, 1));
      req_ch.block_time <= $urandom;
      req_ch.difficulty <= DIFF_W'($urandom_range(0, 127));
      req_ch.reward     <= $urandom;
      req_ch.fees       <= $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic offer_item(logic [CMD_W-1:0] c, logic [TIME_W-1:0] bt,
                             logic [DIFF_W-1:0] d, logic [AMOUNT_W-1:0] r,
                             logic [AMOUNT_W-1:0] f);
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= c;
      req_ch.block_time <= bt;
      req_ch.difficulty <= d;
      req_ch.reward     <= r;
      req_ch.fees       <= f;
      do @(posedge clock); while (!req_ch.ready);
      if (c == CMD_CLEAR) begin
         clears_sent++;
         run_now = 0;
      end else begin
         records_sent++;
         run_now++;
         if (run_now > run_max) run_max = run_now;
      end
      if (back_to_back > 0) back_to_back--;
      else if (!calm && $urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 13));
   endtask

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(1, 1000);
         3, 4:    return $urandom_range(5000, 60000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic offer_random(logic [CMD_W-1:0] c);
      logic [DIFF_W-1:0] d;
      if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1;
      if (random_sent == pressure_at) begin
         hold_off_req = 1;
         back_to_back = 12;
      end
      d = ($urandom_range(0, 7) == 0) ? DIFF_W'($urandom_range(65, 127))
                                      : DIFF_W'($urandom_range(0, 64));
      offer_item(c, pick_time(), d, pick_amount(), pick_amount());
      random_sent++;
   endtask

   initial begin
      int run_len;
      int k;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_RECORD;
      req_ch.block_time = '0;
      req_ch.difficulty = '0;
      req_ch.reward     = '0;
      req_ch.fees       = '0;
      calm         = 0;
      hold_off_req = 0;
      back_to_back = 0;
      records_sent = 0;
      clears_sent  = 0;
      run_now      = 0;
      run_max      = 0;
      random_sent  = 0;
      pressure_at  = $urandom_range(100, 400);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty clear, zero times, extremes, bit patterns
      offer_item(CMD_CLEAR, '0, '0, '0, '0);
      offer_item(CMD_RECORD, '0, '0, '0, '0);
      offer_item(CMD_RECORD, 32'd5000, 7'd64, '1, '1);
      offer_item(CMD_RECORD, '1, 7'd127, '1, '0);
      offer_item(CMD_RECORD, 32'd1, 7'd65, 32'd7, 32'd3);
      offer_item(CMD_RECORD, '0, 7'd10, 32'd1, 32'd1);
      offer_item(CMD_RECORD, 32'd700, 7'd0, '0, '1);
      offer_item(CMD_CLEAR, '1, 7'd127, '1, '1);
      offer_item(CMD_CLEAR, '0, '0, '0, '0);
      offer_item(CMD_RECORD, '1, 7'd64, '1, '1);
      offer_item(CMD_RECORD, '1, 7'd1, '1, '1);
      offer_item(CMD_RECORD, 32'hAAAA_AAAA, 7'h55, 32'h5555_5555, 32'hAAAA_AAAA);
      offer_item(CMD_RECORD, 32'h5555_5555, 7'h2A, 32'hAAAA_AAAA, 32'h5555_5555);
      offer_item(CMD_RECORD, '0, 7'd33, '0, '0);
      offer_item(CMD_CLEAR, '0, '0, '0, '0);

      // random: record runs, most long enough to wrap the window, each closed by a clear
      while (random_sent < RANDOM_ITEMS) begin
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                               : $urandom_range(60, 260);
         for (k = 0; k < run_len && random_sent < RANDOM_ITEMS; k++)
            offer_random(($urandom_range(0, 99) == 0) ? CMD_CLEAR : CMD_RECORD);
         if (random_sent < RANDOM_ITEMS) offer_random(CMD_CLEAR);
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d record and %0d clear items, %0d results checked",
               records_sent, clears_sent, checked);
      $display("longest record run %0d against a window of %0d", run_max, WINDOW_DEF);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
